// ===== hdl/spda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spda_pkg
// Shared widths, codes and control types of the stereo peak, RMS and DC
// offset analyzer.
// ----------------------------------------------------------------------------
package spda_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COUNT_BITS    = 32;
  localparam int OUT_BITS      = 24;
  localparam int SUM_BITS      = 56;
  localparam int SQ_BITS       = 64;
  localparam int SQ_SHIFT      = 16;
  localparam int SQ_ADD_BITS   = 2 * SAMPLE_BITS - SQ_SHIFT;
  localparam int DIVIDEND_BITS = 64;
  localparam int ROOT_BITS     = DIVIDEND_BITS / 2;
  localparam int RMS_SHIFT     = 8;

  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_STEREO = 2'd2;

  typedef enum logic [1:0] {
    JOB_SQ_L,
    JOB_SUM_L,
    JOB_SQ_R,
    JOB_SUM_R
  } job_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_NEXT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic in_take;
    logic div_start;
    logic sqrt_start;
    logic store_mean;
    logic store_rms;
    logic finish;
    job_t job;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sta_valid;
    logic div_done;
    logic sqrt_done;
    logic out_busy;
    logic mono;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/spda_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spda_in_if
// Input channel carrying one stereo frame per transaction.
// ----------------------------------------------------------------------------
interface spda_in_if import spda_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic                          last_frame;

  modport source (output valid, output sample_left, output sample_right,
                  output last_frame, input ready);
  modport sink   (input valid, input sample_left, input sample_right,
                  input last_frame, output ready);
endinterface
`default_nettype wire

// ===== hdl/spda_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spda_out_if
// Result channel carrying the per-channel measurements of one sound.
// ----------------------------------------------------------------------------
interface spda_out_if import spda_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [OUT_BITS-1:0]   peak_left;
  logic        [COUNT_BITS-1:0] peak_index_left;
  logic        [OUT_BITS-1:0]   rms_left;
  logic signed [OUT_BITS-1:0]   mean_left;
  logic        [OUT_BITS-1:0]   peak_right;
  logic        [COUNT_BITS-1:0] peak_index_right;
  logic        [OUT_BITS-1:0]   rms_right;
  logic signed [OUT_BITS-1:0]   mean_right;

  modport source (output valid, output peak_left, output peak_index_left,
                  output rms_left, output mean_left, output peak_right,
                  output peak_index_right, output rms_right, output mean_right,
                  input ready);
  modport sink   (input valid, input peak_left, input peak_index_left,
                  input rms_left, input mean_left, input peak_right,
                  input peak_index_right, input rms_right, input mean_right,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/stereo_peak_rms_dc_analyzer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_peak_rms_dc_analyzer
// Per-channel peak, peak position, RMS level and DC mean of a stereo sound.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Carries
//  in_ch    | sink      | sample_left, sample_right, last_frame
//  out_ch   | source    | peak, peak_index, rms, mean for left and right
//  cfg_*    | write     | channel_mode (1 mono, otherwise stereo)
//
// Frames are taken one per cycle while the sound is being accumulated.
// A last frame closes the sound with in_ch.ready low: a drain, then per
// active channel two divisions and one square root, then the result
// register is loaded once it is free.
// The result register frees the input side while a result waits on out_ch.
// Reset is synchronous and active low and clears all accumulated state.
// ----------------------------------------------------------------------------
module stereo_peak_rms_dc_analyzer import spda_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  spda_in_if.sink         in_ch,
  spda_out_if.source      out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  spda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_frame),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spda_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_left  (in_ch.sample_left),
    .sample_right (in_ch.sample_right),
    .cmd          (cmd),
    .stat         (stat),
    .out_ch       (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

// ===== hdl/spda_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spda_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spda_div import spda_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [COUNT_BITS-1:0]    divisor,
  output logic                          done,
  output logic      [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_BITS-1:0] dvd_r, dvd_nxt;
  logic [COUNT_BITS-1:0]    rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]    dsr_r, dsr_nxt;
  logic [COUNT_BITS:0]      trial;
  logic [COUNT_BITS:0]      diff;
  logic                     ge;

  always_comb begin
    trial    = {rem_r, dvd_r[DIVIDEND_BITS-1]};
    diff     = trial - {1'b0, dsr_r};
    ge       = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIVIDEND_BITS-2:0], ge};
      rem_nxt = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      cnt_nxt = cnt_r + CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(DIVIDEND_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

// ===== hdl/spda_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spda_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module spda_sqrt import spda_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] radicand,
  output logic                          done,
  output logic      [ROOT_BITS-1:0]     root
);

  localparam int CNT_BITS = $clog2(ROOT_BITS);
  localparam int REM_BITS = ROOT_BITS + 1;

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_BITS-1:0] rad_r, rad_nxt;
  logic [REM_BITS-1:0]      rem_r, rem_nxt;
  logic [ROOT_BITS-1:0]     root_r, root_nxt;
  logic [REM_BITS+1:0]      rem_sh;
  logic [REM_BITS+1:0]      trial;
  logic [REM_BITS+1:0]      diff;
  logic                     ge;

  always_comb begin
    rem_sh   = {rem_r, rad_r[DIVIDEND_BITS-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = rem_sh - trial;
    ge       = (rem_sh >= trial);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[DIVIDEND_BITS-3:0], 2'b00};
      rem_nxt  = ge ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
      root_nxt = {root_r[ROOT_BITS-2:0], ge};
      cnt_nxt  = cnt_r + CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(ROOT_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== hdl/spda_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spda_dp
// Datapath: frame pipeline, accumulators, shared divider and square root,
// and the result register.
// ----------------------------------------------------------------------------
module spda_dp import spda_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic        [1:0]             cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
  input  wire ctrl_cmd_t                     cmd,
  output dp_stat_t                           stat,
  spda_out_if.source                         out_ch
);

  logic [1:0] mode_r;

  // Stage A: magnitude and scaled square of each sample.
  logic                          sta_valid_r;
  logic                          sta_mono_r;
  logic signed [SAMPLE_BITS-1:0] sta_s_l_r, sta_s_r_r;
  logic [SAMPLE_BITS-1:0]        sta_mag_l_r, sta_mag_r_r;
  logic [SQ_ADD_BITS-1:0]        sta_sq_l_r, sta_sq_r_r;
  logic [SAMPLE_BITS-1:0]        mag_l, mag_r;
  logic [2*SAMPLE_BITS-1:0]      prod_l, prod_r;

  // Stage B: accumulators.
  logic [SAMPLE_BITS-1:0] peak_l_r, peak_l_nxt, peak_r_r, peak_r_nxt;
  logic [COUNT_BITS-1:0]  pos_l_r, pos_l_nxt, pos_r_r, pos_r_nxt;
  logic [SQ_BITS-1:0]     sq_l_r, sq_l_nxt, sq_r_r, sq_r_nxt;
  logic [SUM_BITS-1:0]    sum_l_r, sum_l_nxt, sum_r_r, sum_r_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                   mono_last_r, mono_last_nxt;
  logic [SQ_BITS:0]       sq_l_add, sq_r_add;

  logic [OUT_BITS-1:0] rms_l_r, rms_r_r, mean_l_r, mean_r_r;

  logic                     div_done, sqrt_done;
  logic [DIVIDEND_BITS-1:0] quotient;
  logic [ROOT_BITS-1:0]     root;
  logic [DIVIDEND_BITS-1:0] dividend;
  logic [SUM_BITS-1:0]      sum_sel, sum_abs;
  logic                     sum_neg;
  logic [OUT_BITS-1:0]      mean_val;
  logic [OUT_BITS-1:0]      rms_val;
  logic                     out_valid_r;
  logic                     right_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STEREO;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign mag_l  = sample_left[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-sample_left)  : sample_left;
  assign mag_r  = sample_right[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_right) : sample_right;
  assign prod_l = mag_l * mag_l;
  assign prod_r = mag_r * mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sta_valid_r <= 1'b0;
    end else begin
      sta_valid_r <= cmd.in_take;
    end
    if (cmd.in_take) begin
      sta_mono_r  <= (mode_r == MODE_MONO);
      sta_s_l_r   <= sample_left;
      sta_s_r_r   <= sample_right;
      sta_mag_l_r <= mag_l;
      sta_mag_r_r <= mag_r;
      sta_sq_l_r  <= prod_l[2*SAMPLE_BITS-1:SQ_SHIFT];
      sta_sq_r_r  <= prod_r[2*SAMPLE_BITS-1:SQ_SHIFT];
    end
  end

  always_comb begin
    peak_l_nxt    = peak_l_r;
    peak_r_nxt    = peak_r_r;
    pos_l_nxt     = pos_l_r;
    pos_r_nxt     = pos_r_r;
    sq_l_nxt      = sq_l_r;
    sq_r_nxt      = sq_r_r;
    sum_l_nxt     = sum_l_r;
    sum_r_nxt     = sum_r_r;
    cnt_nxt       = cnt_r;
    mono_last_nxt = mono_last_r;
    sq_l_add      = {1'b0, sq_l_r} + (SQ_BITS + 1)'(sta_sq_l_r);
    sq_r_add      = {1'b0, sq_r_r} + (SQ_BITS + 1)'(sta_sq_r_r);
    if (cmd.finish) begin
      peak_l_nxt = '0;
      peak_r_nxt = '0;
      pos_l_nxt  = '0;
      pos_r_nxt  = '0;
      sq_l_nxt   = '0;
      sq_r_nxt   = '0;
      sum_l_nxt  = '0;
      sum_r_nxt  = '0;
      cnt_nxt    = '0;
    end else if (sta_valid_r) begin
      mono_last_nxt = sta_mono_r;
      if (sta_mag_l_r > peak_l_r) begin
        peak_l_nxt = sta_mag_l_r;
        pos_l_nxt  = cnt_r;
      end
      sq_l_nxt  = sq_l_add[SQ_BITS] ? '1 : sq_l_add[SQ_BITS-1:0];
      sum_l_nxt = sum_l_r + SUM_BITS'(sta_s_l_r);
      if (!sta_mono_r) begin
        if (sta_mag_r_r > peak_r_r) begin
          peak_r_nxt = sta_mag_r_r;
          pos_r_nxt  = cnt_r;
        end
        sq_r_nxt  = sq_r_add[SQ_BITS] ? '1 : sq_r_add[SQ_BITS-1:0];
        sum_r_nxt = sum_r_r + SUM_BITS'(sta_s_r_r);
      end
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_l_r    <= '0;
      peak_r_r    <= '0;
      pos_l_r     <= '0;
      pos_r_r     <= '0;
      sq_l_r      <= '0;
      sq_r_r      <= '0;
      sum_l_r     <= '0;
      sum_r_r     <= '0;
      cnt_r       <= '0;
      mono_last_r <= 1'b0;
    end else begin
      peak_l_r    <= peak_l_nxt;
      peak_r_r    <= peak_r_nxt;
      pos_l_r     <= pos_l_nxt;
      pos_r_r     <= pos_r_nxt;
      sq_l_r      <= sq_l_nxt;
      sq_r_r      <= sq_r_nxt;
      sum_l_r     <= sum_l_nxt;
      sum_r_r     <= sum_r_nxt;
      cnt_r       <= cnt_nxt;
      mono_last_r <= mono_last_nxt;
    end
  end

  assign right_job = (cmd.job == JOB_SQ_R) || (cmd.job == JOB_SUM_R);
  assign sum_sel   = right_job ? sum_r_r : sum_l_r;
  assign sum_neg   = sum_sel[SUM_BITS-1];
  assign sum_abs   = sum_neg ? (~sum_sel + SUM_BITS'(1)) : sum_sel;

  always_comb begin
    case (cmd.job)
      JOB_SQ_L:  dividend = sq_l_r;
      JOB_SQ_R:  dividend = sq_r_r;
      default:   dividend = DIVIDEND_BITS'(sum_abs);
    endcase
  end

  spda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quotient)
  );

  spda_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (quotient),
    .done     (sqrt_done),
    .root     (root)
  );

  assign mean_val = sum_neg ? (~quotient[OUT_BITS-1:0] + OUT_BITS'(1))
                            : quotient[OUT_BITS-1:0];
  assign rms_val  = {root[OUT_BITS-RMS_SHIFT-1:0], {RMS_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.store_mean) begin
      if (right_job) begin
        mean_r_r <= mean_val;
      end else begin
        mean_l_r <= mean_val;
      end
    end
    if (cmd.store_rms) begin
      if (right_job) begin
        rms_r_r <= rms_val;
      end else begin
        rms_l_r <= rms_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_ch.peak_left        <= peak_l_r;
      out_ch.peak_index_left  <= pos_l_r;
      out_ch.rms_left         <= rms_l_r;
      out_ch.mean_left        <= mean_l_r;
      out_ch.peak_right       <= mono_last_r ? '0 : peak_r_r;
      out_ch.peak_index_right <= mono_last_r ? '0 : pos_r_r;
      out_ch.rms_right        <= mono_last_r ? '0 : rms_r_r;
      out_ch.mean_right       <= mono_last_r ? '0 : mean_r_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign stat.sta_valid = sta_valid_r;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.out_busy  = out_valid_r && !out_ch.ready;
  assign stat.mono      = mono_last_r;

endmodule
`default_nettype wire

// ===== hdl/spda_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spda_ctrl
// Controller: accepts frames and sequences the divisions and square roots
// that close one sound.
// ----------------------------------------------------------------------------
module spda_ctrl import spda_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd
);

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
      job_r   <= JOB_SQ_L;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.job   = job_r;
    case (state_r)
      ST_ACCUM: begin
        in_ready    = 1'b1;
        cmd.in_take = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.sta_valid) begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          if (job_r inside {JOB_SUM_L, JOB_SUM_R}) begin
            cmd.store_mean = 1'b1;
            state_nxt      = ST_NEXT;
          end else begin
            state_nxt = ST_SQRT_GO;
          end
        end
      end
      ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          cmd.store_rms = 1'b1;
          state_nxt     = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if ((job_r == JOB_SUM_R) || ((job_r == JOB_SUM_L) && stat.mono)) begin
          state_nxt = ST_FINISH;
        end else begin
          job_nxt   = job_t'(job_r + 2'd1);
          state_nxt = ST_DIV_GO;
        end
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          job_nxt    = JOB_SQ_L;
          state_nxt  = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/spda_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spda_checker
// Port-level checks of the analyzer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spda_checker import spda_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_last,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [OUT_BITS-1:0] peak_left,
  input wire logic [OUT_BITS-1:0] rms_left,
  input wire logic [OUT_BITS-1:0] peak_right,
  input wire logic [OUT_BITS-1:0] rms_right
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transaction completed");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(peak_left) && $stable(rms_left) &&
                                $stable(peak_right) && $stable(rms_right))
    else $error("result payload changed while stalled");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken while a sound is being closed");

  a_rms_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rms_left <= peak_left) && (rms_right <= peak_right))
    else $error("RMS level exceeds peak");

endmodule

bind stereo_peak_rms_dc_analyzer spda_checker u_spda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_frame),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .peak_left  (out_ch.peak_left),
  .rms_left   (out_ch.rms_left),
  .peak_right (out_ch.peak_right),
  .rms_right  (out_ch.rms_right)
);
`default_nettype wire
